[hw/rtl/assert_macros.svh]
// Assertion macros included by the decoder top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[hw/rtl/glzw_pkg.sv]
// Package for the LZW decoder: constants and types
package glzw_pkg;
   localparam int MaxCodeBits = 12;
   localparam int TableDepth = 1 << MaxCodeBits;
   localparam int BufDepth = 4096;
   localparam int BufAw = $clog2(BufDepth);
   localparam int CntW = 13;
   localparam logic OP_FEED = 1'b0;
   localparam logic OP_FETCH = 1'b1;
   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_NO_CLEAR = 2'd1;
   localparam logic [1:0] ERR_BAD_CODE = 2'd2;
   localparam logic [1:0] ERR_NO_END = 2'd3;

   typedef enum logic [1:0] {
      PH_WAIT_CLEAR, PH_WAIT_FIRST, PH_DECODING, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CODE, ST_LEN, ST_WALK, ST_WRLAST, ST_FETCH, ST_RESP
   } state_type;

   typedef struct packed {
      logic [MaxCodeBits-1:0] prefix;
      logic [7:0]             suffix;
      logic [MaxCodeBits-1:0] len;
   } entry_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
      logic       data_end;
   } req_type;

   typedef struct packed {
      logic [7:0]      pixel_index;
      logic            pixel_valid;
      logic            byte_accepted;
      logic [CntW-1:0] pixels_pending;
      logic            image_done;
      logic [1:0]      error_code;
   } rsp_type;
endpackage

[hw/rtl/glzw_if.sv]
// Valid/ready channel interface carrying one payload
interface glzw_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/glzw_table.sv]
// String table memory: prefix, suffix and length per code
module glzw_table (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [glzw_pkg::MaxCodeBits-1:0] wr_addr,
   input  glzw_pkg::entry_type           wr_data,
   input  logic [glzw_pkg::MaxCodeBits-1:0] rd_addr,
   output glzw_pkg::entry_type           rd_data
);
   import glzw_pkg::*;
   entry_type mem [TableDepth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/glzw_pixbuf.sv]
// Pixel buffer memory
module glzw_pixbuf (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [glzw_pkg::BufAw-1:0] wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic [glzw_pkg::BufAw-1:0] rd_addr,
   output logic [7:0]                 rd_data
);
   import glzw_pkg::*;
   logic [7:0] mem [BufDepth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[hw/rtl/gif_lzw_decoder_top.sv]
// LZW decoder: unpacks codes from fed bytes, expands strings, serves pixels.
// Items are handled one at a time: the next request is taken only after the
// result has been transferred, and the output register holds the result until
// the consumer takes it. A fetch makes one buffer memory read. A fed byte is
// unpacked into codes; a clear, end or bad code is handled on its own, and for
// each data code the string is written to the pixel buffer, as the prefix chain
// is walked one table read per cycle.
module gif_lzw_decoder_top (
   input logic        clock,
   input logic        reset,
   glzw_if.sink       req,
   glzw_if.source     rsp,
   input logic        csr_we,
   input logic [3:0]  csr_wdata
);
   import glzw_pkg::*;
   `include "assert_macros.svh"

   localparam int Cw = MaxCodeBits;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [3:0] mcs_ff, mcs_in;
   logic [19:0] bbuf_ff, bbuf_in;
   logic [4:0] bcnt_ff, bcnt_in;
   logic [3:0] cwid_ff, cwid_in;
   logic [CntW-1:0] nfree_ff, nfree_in;
   logic [Cw-1:0] prev_ff, prev_in;
   logic [7:0] pfirst_ff, pfirst_in;
   logic [CntW-1:0] rptr_ff, rptr_in, fill_ff, fill_in;
   logic [1:0] err_ff, err_in;
   req_type rq_ff, rq_in;
   rsp_type out_ff, out_in;
   logic ovalid_ff, ovalid_in;
   logic acc_ff, acc_in;
   // walk context
   logic [Cw:0] code_ff, code_in;   // current chain code
   logic [Cw-1:0] cur_ff, cur_in;   // decoded code for bookkeeping
   logic [CntW-1:0] start_ff, start_in, pos_ff, pos_in;
   logic [CntW-1:0] len_ff, len_in;
   logic kwk_ff, kwk_in, add_ff, add_in;
   logic [12:0] wcnt_ff, wcnt_in;
   // length of the previous code's string, kept for the table add
   logic [Cw-1:0] t_prev_len_ff, t_prev_len_in;

   logic [3:0] eff;
   logic [CntW-1:0] clr, lim;
   always_comb begin
      eff = mcs_ff < 4'd2 ? 4'd2 : (mcs_ff > 4'd8 ? 4'd8 : mcs_ff);
      clr = CntW'(1) << eff;
      lim = clr + CntW'(2);
   end

   logic t_we;
   logic [Cw-1:0] t_wa, t_ra;
   entry_type t_wd, t_rd;
   glzw_table u_table (.clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd));
   logic p_we;
   logic [BufAw-1:0] p_wa, p_ra;
   logic [7:0] p_wd, p_rd;
   glzw_pixbuf u_pix (.clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data(p_rd));

   logic [Cw:0] code_raw;
   logic [CntW-1:0] code_x;
   always_comb begin
      code_raw = (Cw+1)'(bbuf_ff & ((20'd1 << cwid_ff) - 20'd1));
      code_x = CntW'(code_raw);
   end

   // next free code once a new string is added
   logic [CntW-1:0] nf_inc;
   always_comb begin
      nf_inc = nfree_ff + CntW'(1);
   end

   // chain entry in code_ff still has a suffix to write
   logic walk_more;
   always_comb begin
      walk_more = ({1'b0, code_ff} >= (CntW+1)'(lim)) && (wcnt_ff < 13'(TableDepth));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) state_in = (req.payload.operation == OP_FETCH) ?
                     ST_FETCH : ST_CODE;
         ST_FETCH: state_in = ST_RESP;
         ST_CODE: state_in = ST_RESP;
         ST_LEN: state_in = ST_WALK;
         ST_WALK: state_in = ST_WALK;
         ST_WRLAST: state_in = ST_CODE;
         ST_RESP: if (!ovalid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      // code handling overrides
      if (state_ff == ST_CODE && acc_ff && phase_ff != PH_DONE
          && bcnt_ff >= 5'(cwid_ff)) begin
         state_in = ST_CODE;
         if (phase_ff != PH_WAIT_CLEAR && code_x != clr && code_x != clr + CntW'(1)
             && !(phase_ff == PH_WAIT_FIRST && code_x >= nfree_ff)
             && !(phase_ff == PH_DECODING && (code_x > nfree_ff ||
                  (code_x == nfree_ff && nfree_ff >= CntW'(TableDepth)))))
            state_in = ST_LEN;
      end
      // the repeat-previous case always goes on to walk the previous code's chain
      if (state_ff == ST_WALK && !(wcnt_ff == '0 && kwk_ff) && !walk_more)
         state_in = ST_WRLAST;
      if (state_ff == ST_RESP && ovalid_ff && !rsp.ready) state_in = ST_RESP;
   end

   always_comb begin
      phase_in = phase_ff; mcs_in = mcs_ff; bbuf_in = bbuf_ff; bcnt_in = bcnt_ff;
      cwid_in = cwid_ff; nfree_in = nfree_ff; prev_in = prev_ff;
      pfirst_in = pfirst_ff; rptr_in = rptr_ff; fill_in = fill_ff; err_in = err_ff;
      rq_in = rq_ff; out_in = out_ff; ovalid_in = ovalid_ff; acc_in = acc_ff;
      code_in = code_ff; cur_in = cur_ff; start_in = start_ff; pos_in = pos_ff;
      len_in = len_ff; kwk_in = kwk_ff; add_in = add_ff; wcnt_in = wcnt_ff;
      t_we = 1'b0; t_wa = nfree_ff[Cw-1:0]; t_wd = '0; t_ra = code_ff[Cw-1:0];
      p_we = 1'b0; p_wa = pos_ff[BufAw-1:0]; p_wd = '0; p_ra = rptr_ff[BufAw-1:0];
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            rq_in = req.payload;
            acc_in = 1'b0;
            if (req.valid && req.payload.operation == OP_FEED &&
                rptr_ff >= fill_ff && phase_ff != PH_DONE) begin
               acc_in = 1'b1;
               rptr_in = '0; fill_in = '0;
               bbuf_in = bbuf_ff | (20'(req.payload.data_byte) <<
                  (bcnt_ff > 5'd12 ? 5'd12 : bcnt_ff));
               bcnt_in = (bcnt_ff > 5'd12 ? 5'd12 : bcnt_ff) + 5'd8;
            end
         end
         ST_CODE: begin
            if (acc_ff && phase_ff != PH_DONE && bcnt_ff >= 5'(cwid_ff)) begin
               bbuf_in = bbuf_ff >> cwid_ff;
               bcnt_in = bcnt_ff - 5'(cwid_ff);
               cur_in = code_raw[Cw-1:0];
               code_in = code_raw;
               if (phase_ff == PH_WAIT_CLEAR) begin
                  if (code_x == clr) begin
                     cwid_in = eff + 4'd1; nfree_in = lim; phase_in = PH_WAIT_FIRST;
                  end else begin
                     err_in = ERR_NO_CLEAR; phase_in = PH_DONE;
                  end
               end else if (code_x == clr) begin
                  cwid_in = eff + 4'd1; nfree_in = lim; phase_in = PH_WAIT_FIRST;
               end else if (code_x == clr + CntW'(1)) begin
                  phase_in = PH_DONE;
               end else if (phase_ff == PH_WAIT_FIRST) begin
                  if (code_x >= nfree_ff) begin
                     err_in = ERR_BAD_CODE; phase_in = PH_DONE;
                  end else begin
                     kwk_in = 1'b0; add_in = 1'b0;
                  end
               end else if (code_x < nfree_ff) begin
                  kwk_in = 1'b0; add_in = 1'b1;
               end else if (code_x == nfree_ff && nfree_ff < CntW'(TableDepth)) begin
                  kwk_in = 1'b1; add_in = 1'b1;
                  // the walk adds the entry: previous string plus its first pixel
                  code_in = {1'b0, prev_ff};
               end else begin
                  err_in = ERR_BAD_CODE; phase_in = PH_DONE;
               end
            end else begin
               if (acc_ff && rq_ff.data_end && phase_ff != PH_DONE) begin
                  err_in = ERR_NO_END; phase_in = PH_DONE;
               end
               ovalid_in = 1'b1;
               out_in.pixel_index = '0; out_in.pixel_valid = 1'b0;
               out_in.byte_accepted = acc_ff;
               out_in.pixels_pending = fill_ff - rptr_ff;
               out_in.image_done = (phase_in == PH_DONE);
               out_in.error_code = err_in;
            end
         end
         ST_LEN: begin
            // table read of code_ff issued; length arrives next cycle
            t_ra = code_ff[Cw-1:0];
            start_in = fill_ff;
            wcnt_in = '0;
         end
         ST_WALK: begin
            if (wcnt_ff == '0) begin
               // first cycle: resolve the string length
               len_in = ({1'b0, code_ff} < (CntW+1)'(lim)) ? CntW'(1) :
                  CntW'(t_rd.len);
               if (kwk_ff) begin
                  // previous string length plus one is the new string
                  len_in = (({1'b0, code_ff} < (CntW+1)'(lim)) ? CntW'(1) :
                     CntW'(t_rd.len)) + CntW'(1);
                  len_in = CntW'(len_in[Cw-1:0]);
               end
               pos_in = start_ff + len_in;
               if (kwk_ff) begin
                  t_we = 1'b1;
                  t_wa = nfree_ff[Cw-1:0];
                  t_wd.prefix = prev_ff; t_wd.suffix = pfirst_ff;
                  t_wd.len = len_in[Cw-1:0];
                  // the new entry is known: write its suffix and go on with the prefix
                  if (pos_in > start_ff) pos_in = pos_in - CntW'(1);
                  p_we = (pos_in < CntW'(BufDepth));
                  p_wa = pos_in[BufAw-1:0];
                  p_wd = pfirst_ff;
                  code_in = {1'b0, prev_ff};
                  t_ra = prev_ff;
                  wcnt_in = 13'd2;
               end else begin
                  wcnt_in = 13'd1;
                  t_ra = code_ff[Cw-1:0];
               end
            end else if (walk_more) begin
               // write suffix of chain entry, follow prefix
               if (pos_ff > start_ff) pos_in = pos_ff - CntW'(1);
               p_we = (pos_in < CntW'(BufDepth));
               p_wa = pos_in[BufAw-1:0];
               p_wd = t_rd.suffix;
               code_in = {1'b0, t_rd.prefix};
               t_ra = t_rd.prefix;
               wcnt_in = wcnt_ff + 13'd1;
            end
         end
         ST_WRLAST: begin
            if (pos_ff > start_ff) pos_in = pos_ff - CntW'(1);
            p_we = (pos_in < CntW'(BufDepth));
            p_wa = pos_in[BufAw-1:0];
            p_wd = code_ff[7:0];
            fill_in = (start_ff + len_ff > CntW'(BufDepth)) ? CntW'(BufDepth) :
               start_ff + len_ff;
            pfirst_in = code_ff[7:0];
            prev_in = cur_ff;
            phase_in = PH_DECODING;
            if (add_ff && !kwk_ff && nfree_ff < CntW'(TableDepth)) begin
               t_we = 1'b1;
               t_wa = nfree_ff[Cw-1:0];
               t_wd.prefix = prev_ff; t_wd.suffix = code_ff[7:0];
               t_wd.len = (({1'b0, prev_ff} < (CntW+1)'(lim)) ? Cw'(1) :
                  t_prev_len_ff) + Cw'(1);
            end
            if (add_ff && nfree_ff < CntW'(TableDepth)) begin
               nfree_in = nf_inc;
               if (nf_inc == (CntW'(1) << cwid_ff) && cwid_ff < 4'(MaxCodeBits))
                  cwid_in = cwid_ff + 4'd1;
            end
         end
         ST_FETCH: begin
            ovalid_in = 1'b1;
            out_in = '0;
            if (rptr_ff < fill_ff) begin
               out_in.pixel_index = (rptr_ff < CntW'(BufDepth)) ? p_rd : 8'd0;
               out_in.pixel_valid = 1'b1;
               rptr_in = rptr_ff + CntW'(1);
               if (rptr_in >= fill_ff) begin
                  rptr_in = '0; fill_in = '0;
               end
            end
            out_in.pixels_pending = fill_in - rptr_in;
            out_in.image_done = (phase_ff == PH_DONE);
            out_in.error_code = err_ff;
         end
         default: ;
      endcase
      if (csr_we) begin
         mcs_in = csr_wdata;
      end
   end

   always_comb begin
      t_prev_len_in = t_prev_len_ff;
      if (state_ff == ST_WRLAST)
         t_prev_len_in = len_ff[Cw-1:0];
   end

   logic [3:0] eff_new;
   always_comb begin
      eff_new = csr_wdata < 4'd2 ? 4'd2 : (csr_wdata > 4'd8 ? 4'd8 : csr_wdata);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_WAIT_CLEAR;
         bbuf_ff <= '0; bcnt_ff <= '0;
         prev_ff <= '0; pfirst_ff <= '0;
         rptr_ff <= '0; fill_ff <= '0; err_ff <= ERR_NONE;
         ovalid_ff <= 1'b0; acc_ff <= 1'b0;
         t_prev_len_ff <= Cw'(1);
         if (reset) begin
            mcs_ff <= 4'd8; cwid_ff <= 4'd9; nfree_ff <= CntW'(258);
         end else begin
            mcs_ff <= mcs_in; cwid_ff <= eff_new + 4'd1;
            nfree_ff <= (CntW'(1) << eff_new) + CntW'(2);
         end
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; mcs_ff <= mcs_in;
         bbuf_ff <= bbuf_in; bcnt_ff <= bcnt_in; cwid_ff <= cwid_in;
         nfree_ff <= nfree_in; prev_ff <= prev_in; pfirst_ff <= pfirst_in;
         rptr_ff <= rptr_in; fill_ff <= fill_in; err_ff <= err_in;
         ovalid_ff <= ovalid_in; acc_ff <= acc_in;
         t_prev_len_ff <= t_prev_len_in;
      end
      rq_ff <= rq_in; out_ff <= out_in; code_ff <= code_in; cur_ff <= cur_in;
      start_ff <= start_in; pos_ff <= pos_in; len_ff <= len_in;
      kwk_ff <= kwk_in; add_ff <= add_in; wcnt_ff <= wcnt_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.payload = out_ff;

   `ASSERT_IMPL(a_count_order, clock, reset, 1'b1, rptr_ff <= fill_ff)
   `ASSERT_IMPL(a_width_cap, clock, reset, 1'b1, cwid_ff <= 4'(MaxCodeBits))
   `ASSERT_NEXT(a_hold_rsp, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(out_ff))
endmodule
